// ----- rtl/core/wsdf_pkg.sv -----
// ----------------------------------------------------------------------------
// wsdf_pkg
// Shared types and constants for the frame deframer: the length codes of the
// frame header, the work codes passed from the header parser to the output
// stage, and the queue entry format.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KEY_NUM  = 4;
  localparam int unsigned KEY_IW   = 2;
  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned Q_AW     = 2;
  localparam int unsigned Q_CW     = 3;

  // Seven-bit length values that select an extended length field.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef logic [2:0] wsdf_op_t;

  localparam wsdf_op_t OP_PASS      = 3'd0;  // raw byte, framing off
  localparam wsdf_op_t OP_KEY       = 3'd1;  // store one mask byte
  localparam wsdf_op_t OP_KEY_EMPTY = 3'd2;  // last mask byte of a zero-length frame
  localparam wsdf_op_t OP_DATA      = 3'd3;  // payload byte
  localparam wsdf_op_t OP_DATA_LAST = 3'd4;  // final payload byte

  typedef struct packed {
    wsdf_op_t            op;
    logic [KEY_IW-1:0]   key_idx;
    logic [BYTE_W-1:0]   data;
  } wsdf_entry_t;

  typedef struct packed {
    logic        valid;
    wsdf_entry_t entry;
  } wsdf_push_t;

endpackage

// ----- rtl/core/wsdf_front.sv -----
// ----------------------------------------------------------------------------
// wsdf_front
// Header parser. Accepts received words, tracks the frame header and the
// payload length; each raw, mask or payload word becomes one queue entry.
// ----------------------------------------------------------------------------
module wsdf_front
  import wsdf_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic              q_full,
  output wsdf_push_t        push
);

  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_LEN7    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic                   framing_r, framing_nxt;
  logic [2:0]             phase_r, phase_nxt;
  logic [3:0]             hdr_cnt_r, hdr_cnt_nxt;
  logic [LENGTH_BITS-1:0] remain_r, remain_nxt;

  logic       accept;
  logic [6:0] len7;
  logic [3:0] hdr_dec;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign len7     = in_rx_byte[6:0];
  assign hdr_dec  = hdr_cnt_r - 4'd1;

  always_comb begin
    framing_nxt = framing_r;
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    remain_nxt  = remain_r;
    push        = '0;
    push.entry.data = in_rx_byte;

    if (cfg_wr_en) begin
      framing_nxt = cfg_wr_data;
      phase_nxt   = PH_FIRST;
      hdr_cnt_nxt = '0;
      remain_nxt  = '0;
    end else if (accept) begin
      if (!framing_r) begin
        push.valid    = 1'b1;
        push.entry.op = OP_PASS;
      end else begin
        unique case (phase_r)
          PH_LEN7: begin
            remain_nxt = '0;
            if (len7 == LEN_EXT16) begin
              hdr_cnt_nxt = 4'd2;
              phase_nxt   = PH_EXTLEN;
            end else if (len7 == LEN_EXT64) begin
              hdr_cnt_nxt = 4'd8;
              phase_nxt   = PH_EXTLEN;
            end else begin
              remain_nxt  = LENGTH_BITS'(len7);
              hdr_cnt_nxt = 4'd4;
              phase_nxt   = PH_MASK;
            end
          end
          PH_EXTLEN: begin
            // A length that would overflow the counter saturates.
            if (remain_r[LENGTH_BITS-1 -: 8] != '0) begin
              remain_nxt = '1;
            end else begin
              remain_nxt = {remain_r[LENGTH_BITS-9:0], in_rx_byte};
            end
            hdr_cnt_nxt = hdr_dec;
            if (hdr_dec == '0) begin
              hdr_cnt_nxt = 4'd4;
              phase_nxt   = PH_MASK;
            end
          end
          PH_MASK: begin
            push.valid         = 1'b1;
            push.entry.op      = OP_KEY;
            push.entry.key_idx = KEY_IW'(2'd0 - hdr_cnt_r[1:0]);
            hdr_cnt_nxt        = hdr_dec;
            if (hdr_dec == '0) begin
              if (remain_r == '0) begin
                push.entry.op = OP_KEY_EMPTY;
                phase_nxt     = PH_FIRST;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            push.valid = 1'b1;
            remain_nxt = remain_r - LENGTH_BITS'(1);
            if (remain_r == LENGTH_BITS'(1)) begin
              push.entry.op = OP_DATA_LAST;
              phase_nxt     = PH_FIRST;
              hdr_cnt_nxt   = '0;
              remain_nxt    = '0;
            end else begin
              push.entry.op = OP_DATA;
            end
          end
          default: begin
            // First header byte carries nothing we use.
            hdr_cnt_nxt = '0;
            remain_nxt  = '0;
            phase_nxt   = PH_LEN7;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      framing_r <= 1'b0;
      phase_r   <= PH_FIRST;
      hdr_cnt_r <= '0;
      remain_r  <= '0;
    end else begin
      framing_r <= framing_nxt;
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      remain_r  <= remain_nxt;
    end
  end

endmodule

// ----- rtl/core/wsdf_queue.sv -----
// ----------------------------------------------------------------------------
// wsdf_queue
// Short first-in first-out queue of work entries between parser and output
// stage, so that either side can stall without stopping the other at once.
// ----------------------------------------------------------------------------
module wsdf_queue
  import wsdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  wsdf_push_t  push,
  output logic        full,
  output logic        head_valid,
  output wsdf_entry_t head,
  input  logic        pop
);

  wsdf_entry_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]      count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full       = (count_r == Q_CW'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + Q_CW'(do_push) - Q_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

// ----- rtl/core/wsdf_back.sv -----
// ----------------------------------------------------------------------------
// wsdf_back
// Output stage. Holds the mask key, unmasks payload words, forwards raw words
// and empty-frame markers, and drives the registered result channel.
// ----------------------------------------------------------------------------
module wsdf_back
  import wsdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  wsdf_entry_t       head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_in_frame,
  output logic              out_empty_frame
);

  logic [BYTE_W-1:0] key_r [KEY_NUM];
  logic [KEY_IW-1:0] midx_r, midx_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [BYTE_W-1:0] obyte_r, obyte_nxt;
  logic              olast_r, olast_nxt;
  logic              oempty_r, oempty_nxt;
  logic              is_key_only;
  logic              slot_free;
  logic              key_wr;

  assign is_key_only = (head.op == OP_KEY);
  assign slot_free   = !ovalid_r || out_ready;
  assign pop         = head_valid && (is_key_only || slot_free);
  assign key_wr      = pop && (head.op == OP_KEY || head.op == OP_KEY_EMPTY);

  always_comb begin
    midx_nxt   = midx_r;
    ovalid_nxt = ovalid_r && !out_ready;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    oempty_nxt = oempty_r;
    if (pop) begin
      unique case (head.op)
        OP_PASS: begin
          ovalid_nxt = 1'b1;
          obyte_nxt  = head.data;
          olast_nxt  = 1'b0;
          oempty_nxt = 1'b0;
        end
        OP_KEY: begin
          midx_nxt = '0;
        end
        OP_KEY_EMPTY: begin
          midx_nxt   = '0;
          ovalid_nxt = 1'b1;
          obyte_nxt  = '0;
          olast_nxt  = 1'b1;
          oempty_nxt = 1'b1;
        end
        OP_DATA, OP_DATA_LAST: begin
          midx_nxt   = midx_r + KEY_IW'(1);
          ovalid_nxt = 1'b1;
          obyte_nxt  = head.data ^ key_r[midx_r];
          olast_nxt  = (head.op == OP_DATA_LAST);
          oempty_nxt = 1'b0;
        end
        default: begin
          midx_nxt = midx_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      midx_r   <= '0;
    end else begin
      ovalid_r <= ovalid_nxt;
      midx_r   <= midx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obyte_r  <= obyte_nxt;
    olast_r  <= olast_nxt;
    oempty_r <= oempty_nxt;
    if (key_wr) begin
      key_r[head.key_idx] <= head.data;
    end
  end

  assign out_valid         = ovalid_r;
  assign out_byte          = obyte_r;
  assign out_last_in_frame = olast_r;
  assign out_empty_frame   = oempty_r;

endmodule

// ----- rtl/core/websocket_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Strips WebSocket frame headers from a received byte stream and unmasks the
// payload, or passes raw bytes through when framing is off.
//
// Usage:
//   Input channel (in_valid/in_ready/in_rx_byte) takes one received word.
//   Result channel (out_valid/out_ready/out_*) gives one word per payload
//   byte, one marker word per zero-length frame, or one word per raw byte in
//   pass-through mode. Header and mask bytes give no result.
//   cfg_wr_en/cfg_wr_data set framing on or off and restart the header
//   parser; write only while the block is idle.
//   A word that gives a result is written into the queue and then into the
//   registered output stage before it appears on the output.
//   Throughput: one word per cycle while the queue is not full, set by the
//   header parser and the registered output stage.
//   A four-entry queue sits between parser and output; when the receiver
//   holds out_ready low the queue fills and in_ready drops once it is full.
//   Reset (rst_n low, synchronous) clears the queue, the output register and
//   the parser, and turns framing off.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
  import wsdf_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_in_frame,
  output logic              out_empty_frame
);

  wsdf_push_t  push;
  logic        q_full;
  logic        head_valid;
  wsdf_entry_t head;
  logic        pop;

  wsdf_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push)
  );

  wsdf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (q_full),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  wsdf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_in_frame(out_last_in_frame),
    .out_empty_frame  (out_empty_frame)
  );

endmodule

// ----- rtl/core/wsdf_checker.sv -----
// ----------------------------------------------------------------------------
// wsdf_checker
// Port-level checks for the deframer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module wsdf_checker
  import wsdf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_byte,
  input logic              out_last_in_frame,
  input logic              out_empty_frame
);

  // A stalled result word must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(out_last_in_frame) && $stable(out_empty_frame))
    else $error("result word changed while stalled");

  // An empty-frame marker ends its frame and carries a zero word.
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_frame |-> out_last_in_frame && (out_byte == '0))
    else $error("malformed empty-frame marker");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind websocket_frame_deframer wsdf_checker u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_byte         (out_byte),
  .out_last_in_frame(out_last_in_frame),
  .out_empty_frame  (out_empty_frame)
);
